>>> design/mlfe_pkg.sv
// Shared types and constants of the multichannel linear fade engine.
package mlfe_pkg;
	localparam int NUM_CHANNELS = 16;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int MAX_RESULTS = 16;
	localparam int MS_PER_SECOND = 1000;
	localparam int DIV_STEPS = 40;

	typedef enum logic [1:0] {
		CMD_SET_FADE = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_REFRESH  = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic       set_fade;
		logic       tick;
		logic       scan_start;
		logic       scan_next;
		logic       calc_start;
		logic       div_step;
		logic       commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       found;
		logic       scan_end;
		logic       need_div;
		logic       div_done;
		logic       more_after;
	} dp_stat_t;
endpackage

>>> design/mlfe_datapath.sv
// Channel state, millisecond clock, scan pointer and serial divider.
module mlfe_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mlfe_pkg::dp_cmd_t         cmd,
	output mlfe_pkg::dp_stat_t        stat,
	input  logic [3:0]                in_ch,
	input  logic [7:0]                in_target,
	input  logic [15:0]               in_secs,
	output logic [3:0]                res_ch,
	output logic [7:0]                res_level
);
	import mlfe_pkg::*;

	logic [31:0] now_q;
	logic [NUM_CHANNELS-1:0] active_q;
	logic [7:0]  start_lvl_q [NUM_CHANNELS];
	logic [7:0]  end_lvl_q   [NUM_CHANNELS];
	logic [7:0]  cur_lvl_q   [NUM_CHANNELS];
	logic [31:0] start_ms_q  [NUM_CHANNELS];
	logic [15:0] len_q       [NUM_CHANNELS];
	logic [CH_W:0] ptr_q;
	logic [4:0]  cnt_q;
	logic [CH_W-1:0] idx;
	logic [39:0] rem_q;
	logic [39:0] num_q;
	logic [31:0] span_q;
	logic [5:0]  step_q;
	logic        neg_q;
	logic [7:0]  base_q;
	logic [7:0]  lvl_q;
	logic        clr_q;
	logic [31:0] elapsed, span;
	logic [8:0]  diff_mag;
	logic        diff_neg;
	logic [40:0] trial;
	logic [8:0]  q_mag;
	logic [9:0]  lvl_sum;
	logic        more;

	assign idx = ptr_q[CH_W-1:0];
	assign elapsed = now_q - start_ms_q[idx];
	assign span = 32'(len_q[idx]) * 32'(MS_PER_SECOND);
	assign diff_neg = end_lvl_q[idx] < start_lvl_q[idx];
	assign diff_mag = diff_neg ? 9'(start_lvl_q[idx] - end_lvl_q[idx])
		: 9'(end_lvl_q[idx] - start_lvl_q[idx]);
	assign trial = {rem_q, num_q[39]} - {9'd0, span_q};
	assign q_mag = num_q[8:0];
	assign lvl_sum = neg_q ? (10'(base_q) - 10'(q_mag)) : (10'(base_q) + 10'(q_mag));

	always_comb begin
		more = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++)
			if (i > int'(ptr_q) && active_q[i]) more = 1'b1;
	end

	assign stat.found = (ptr_q < (CH_W+1)'(NUM_CHANNELS)) && active_q[idx]
		&& (cnt_q < 5'(MAX_RESULTS));
	assign stat.scan_end = (ptr_q >= (CH_W+1)'(NUM_CHANNELS)) || (cnt_q >= 5'(MAX_RESULTS));
	assign stat.need_div = (elapsed <= span) && (span != 32'd0)
		&& (cur_lvl_q[idx] != end_lvl_q[idx]);
	assign stat.div_done = (step_q == 6'd0);
	// cnt_q already counts the beat being emitted
	assign stat.more_after = more && (cnt_q < 5'(MAX_RESULTS));
	assign res_ch = 4'(idx);
	assign res_level = lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			active_q <= '0;
			ptr_q <= '0;
			cnt_q <= '0;
			step_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			span_q <= '0;
			neg_q <= 1'b0;
			base_q <= '0;
			lvl_q <= '0;
			clr_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				start_lvl_q[i] <= '0;
				end_lvl_q[i] <= '0;
				cur_lvl_q[i] <= '0;
				start_ms_q[i] <= '0;
				len_q[i] <= '0;
			end
		end else begin
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.set_fade && (5'(in_ch) < 5'(NUM_CHANNELS))) begin
				active_q[CH_W'(in_ch)] <= 1'b1;
				start_ms_q[CH_W'(in_ch)] <= now_q;
				start_lvl_q[CH_W'(in_ch)] <= cur_lvl_q[CH_W'(in_ch)];
				len_q[CH_W'(in_ch)] <= in_secs;
				end_lvl_q[CH_W'(in_ch)] <= in_target;
			end
			if (cmd.scan_start) begin
				ptr_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.scan_next) ptr_q <= ptr_q + 1'b1;
			if (cmd.calc_start) begin
				// elapsed stays below 2^26 on a running fade; divide by span serially
				num_q <= 40'(35'(elapsed[25:0]) * 35'(diff_mag));
				rem_q <= '0;
				span_q <= span;
				neg_q <= diff_neg;
				base_q <= start_lvl_q[idx];
				step_q <= 6'(DIV_STEPS);
				lvl_q <= end_lvl_q[idx];
				clr_q <= !stat.need_div;
			end
			if (cmd.div_step) begin
				step_q <= step_q - 6'd1;
				if (!trial[40]) begin
					rem_q <= trial[39:0];
					num_q <= {num_q[38:0], 1'b1};
				end else begin
					rem_q <= {rem_q[38:0], num_q[39]};
					num_q <= {num_q[38:0], 1'b0};
				end
			end
			if (cmd.commit) begin
				if (!clr_q) lvl_q <= lvl_sum[7:0];
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.commit && clr_q) begin
				active_q[idx] <= 1'b0;
				end_lvl_q[idx] <= '0;
				len_q[idx] <= '0;
				cur_lvl_q[idx] <= end_lvl_q[idx];
			end else if (cmd.commit) begin
				cur_lvl_q[idx] <= lvl_sum[7:0];
			end
		end
	end
endmodule

>>> design/mlfe_ctrl.sv
// Sequencer of commands: scan, divide, commit and emit.
module mlfe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_cmd,
	output mlfe_pkg::dp_cmd_t    cmd,
	input  mlfe_pkg::dp_stat_t   stat,
	output logic                 out_load,
	output logic                 out_last,
	input  logic                 out_free
);
	import mlfe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_CMT  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		out_load = 1'b0;
		out_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd_t'(in_cmd))
						CMD_SET_FADE: cmd.set_fade = 1'b1;
						CMD_TICK: cmd.tick = 1'b1;
						CMD_REFRESH: begin
							cmd.scan_start = 1'b1;
							state_d = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.scan_end) state_d = ST_IDLE;
				else if (stat.found) begin
					cmd.calc_start = 1'b1;
					state_d = ST_DIV;
				end else cmd.scan_next = 1'b1;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_CMT;
				else cmd.div_step = 1'b1;
			end
			ST_CMT: begin
				cmd.commit = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = !stat.more_after;
					cmd.scan_next = 1'b1;
					state_d = stat.more_after ? ST_SCAN : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> design/multichannel_linear_fade_engine_top.sv
// Top level of the multichannel linear fade engine.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  s_axis  | in        | channel_index[3:0], target_level, fade_secs | command[1:0]
//  m_axis  | out       | out_channel[3:0], out_level[7:0]            | tlast=last_of_refresh
//
// A refresh walks the channels in order; each active channel gets a 40-step serial
// divide, its done check, commit and emit. The walk ends with the last active
// channel's emit, or with a closing scan when no channel is active.
// Reset is asynchronous, active low, and clears all channel state at once.
// A stalled m_axis holds the walk; one result register buffers the beat.
module multichannel_linear_fade_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // channel_index[3:0], target_level[11:4], fade_seconds[27:12]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_channel[3:0], out_level[11:4]
	output logic        m_axis_tlast
);
	import mlfe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [3:0] res_ch;
	logic [7:0] res_level;
	logic out_load, out_last, out_free;
	logic vld_q, last_q;
	logic [15:0] data_q;

	assign out_free = !vld_q || m_axis_tready;

	mlfe_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(s_axis_tuser),
		.cmd, .stat, .out_load, .out_last, .out_free
	);

	mlfe_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_ch(s_axis_tdata[3:0]), .in_target(s_axis_tdata[11:4]),
		.in_secs(s_axis_tdata[27:12]),
		.res_ch, .res_level
	);

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (out_load) vld_q <= 1'b1;
		else if (m_axis_tready) vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			data_q <= {4'd0, res_level, res_ch};
			last_q <= out_last;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tlast = last_q;
endmodule

>>> design/mlfe_checker.sv
// Port-level checks of the fade engine, bound to the top level.
module mlfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped while stalled");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
		else $error("pad bits set");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken inside a refresh");
endmodule

bind multichannel_linear_fade_engine_top mlfe_checker u_chk (.*);
